[rtl/core/pfc_pkg.sv]
// Shared constants, register codes and the arctangent table for the
// point crop and transform block. No dependencies.
package pfc_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int WORK_FRAC    = 24;
  localparam int ACC_W        = 29;
  localparam int SQRT_N_W     = 64;
  localparam int SQRT_REM_W   = 35;
  localparam int SQRT_ROOT_W  = 32;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int ENTRY_W      = 16;
  localparam int SHIFT_W      = 21;
  localparam int SHIFT_S_W    = 6;
  localparam logic [ACC_W-1:0] PI_Q24 = ACC_W'(52707179);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN = 3'd0,
    REG_RANGE_MAX = 3'd1,
    REG_FOV       = 3'd2,
    REG_ROW_X     = 3'd3,
    REG_ROW_Y     = 3'd4,
    REG_ROW_Z     = 3'd5,
    REG_SHIFT     = 3'd6
  } cfg_idx_t;

  function automatic logic [ACC_W-1:0] atan_q24(input int step);
    logic [ACC_W-1:0] v;
    case (step)
      0:  v = ACC_W'(13176795);
      1:  v = ACC_W'(7778716);
      2:  v = ACC_W'(4110060);
      3:  v = ACC_W'(2086331);
      4:  v = ACC_W'(1047214);
      5:  v = ACC_W'(524117);
      6:  v = ACC_W'(262123);
      7:  v = ACC_W'(131069);
      default: v = (step < CORDIC_STEPS) ? (ACC_W'(1) << (24 - step)) : '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/pfc_stream_if.sv]
// Valid/ready stream interfaces for sensor points in and world points out.
// Depends on nothing.
interface pfc_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] sensor_x;
  logic signed [COORD_BITS-1:0] sensor_y;
  logic signed [COORD_BITS-1:0] sensor_z;
  modport source (output valid, sensor_x, sensor_y, sensor_z, input ready);
  modport sink   (input valid, sensor_x, sensor_y, sensor_z, output ready);
endinterface

interface pfc_out_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] world_x;
  logic signed [COORD_BITS-1:0] world_y;
  logic signed [COORD_BITS-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

[rtl/core/pfc_cordic_cell.sv]
// One vectoring rotation of the arctangent chain.
// Depends on pfc_pkg for the angle table.
module pfc_cordic_cell import pfc_pkg::*; #(
  parameter int STEP = 0,
  parameter int CW   = 60
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    x_i,
  input  logic signed [CW-1:0]    y_i,
  input  logic signed [ACC_W-1:0] a_i,
  output logic signed [CW-1:0]    x_r,
  output logic signed [CW-1:0]    y_r,
  output logic signed [ACC_W-1:0] a_r
);
  localparam logic signed [ACC_W-1:0] ATAN_C = atan_q24(STEP);

  logic signed [CW-1:0] dx, dy;
  assign dx = y_i >>> STEP;
  assign dy = x_i >>> STEP;

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[CW-1]) begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        a_r <= a_i + ATAN_C;
      end else begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        a_r <= a_i - ATAN_C;
      end
    end
  end
endmodule

[rtl/core/pfc_sqrt_cell.sv]
// One digit of the restoring integer square root chain.
// Depends on pfc_pkg for the word widths.
module pfc_sqrt_cell import pfc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SQRT_N_W-1:0]    n_i,
  input  logic [SQRT_REM_W-1:0]  rem_i,
  input  logic [SQRT_ROOT_W-1:0] root_i,
  output logic [SQRT_N_W-1:0]    n_r,
  output logic [SQRT_REM_W-1:0]  rem_r,
  output logic [SQRT_ROOT_W-1:0] root_r
);
  logic [SQRT_REM_W-1:0] rsh, trial;
  assign rsh   = {rem_i[SQRT_REM_W-3:0], n_i[SQRT_N_W-1-2*STEP -: 2]};
  assign trial = {1'b0, root_i, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= n_i;
      if (rsh >= trial) begin
        rem_r  <= rsh - trial;
        root_r <= {root_i[SQRT_ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rsh;
        root_r <= {root_i[SQRT_ROOT_W-2:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/point_fov_crop_and_rigid_transform_top.sv]
// Point field-of-view crop and rigid transform, one point per cycle while the output is not stalled.
// Each accepted input beat reaches its output beat through the 32-cell square root
// chain followed by the 24-cell elevation arctangent chain.
// Throughput: one beat per cycle; the whole chain holds while the output waits.
// Reset (rst_n low, synchronous) empties the pipeline and loads default registers.
// Depends on pfc_pkg, pfc_stream_if, pfc_cordic_cell and pfc_sqrt_cell.
module point_fov_crop_and_rigid_transform_top import pfc_pkg::*; #(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pfc_in_if.sink                in_ch,
  pfc_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int CB    = COORD_BITS;
  localparam int SQ_W  = 2 * CB + 2;
  localparam int CMPW  = (SQ_W > 48) ? SQ_W : 48;
  localparam int CW    = ((CB + 1 > 34) ? CB + 1 : 34) + WORK_FRAC + 2;
  localparam int BSH   = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int BW    = ACC_W + 5;
  localparam int PRD_W = CB + ENTRY_W;
  localparam int PW    = CB + 19;

  localparam int ST_AZ0  = 3;
  localparam int ST_SQ0  = 4;
  localparam int ST_AZIN = ST_AZ0 + CORDIC_STEPS + 1;
  localparam int ST_EL0  = ST_SQ0 + SQRT_STEPS + 1;
  localparam int ST_CMP  = ST_EL0 + CORDIC_STEPS + 1;
  localparam int ST_LAST = ST_CMP + 1;

  typedef struct packed {
    logic                    v;
    logic                    keep;
    logic                    az_zero;
    logic [SHIFT_S_W-1:0]    s;
    logic signed [CB-1:0]    x;
    logic signed [CB-1:0]    y;
    logic signed [CB-1:0]    z;
    logic signed [ACC_W-1:0] az;
  } side_t;

  // configuration registers
  logic [47:0] range_min_r, range_max_r;
  logic [63:0] fov_r;
  logic [47:0] row_r [3];
  logic [62:0] shift_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= 48'd22500;
      range_max_r <= 48'd100000000;
      fov_r       <= '0;
      row_r[0]    <= 48'd16384;
      row_r[1]    <= 48'd16384 << 16;
      row_r[2]    <= 48'd16384 << 32;
      shift_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN: range_min_r <= cfg_wdata[47:0];
        REG_RANGE_MAX: range_max_r <= cfg_wdata[47:0];
        REG_FOV:       fov_r       <= cfg_wdata;
        REG_ROW_X:     row_r[0]    <= cfg_wdata[47:0];
        REG_ROW_Y:     row_r[1]    <= cfg_wdata[47:0];
        REG_ROW_Z:     row_r[2]    <= cfg_wdata[47:0];
        REG_SHIFT:     shift_r     <= cfg_wdata[62:0];
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  side_t sb_r [1:ST_LAST];
  side_t sb_nxt [1:ST_LAST];

  // squares and sums
  logic [2*CB-1:0] sqx_r, sqy_r, sqz_r;
  logic [SQ_W-1:0] sum_xy_r, sum_r, sum_xy_nxt, sum_nxt;
  logic            range_ok;
  logic [SHIFT_S_W-1:0] s_nxt;
  logic [SQRT_N_W-1:0]  n_nxt;

  assign sum_xy_nxt = SQ_W'(sqx_r) + SQ_W'(sqy_r);
  assign sum_nxt    = sum_xy_nxt + SQ_W'(sqz_r);
  assign range_ok   = (CMPW'(sum_nxt) > CMPW'(range_min_r)) &&
                      (CMPW'(sum_nxt) <= CMPW'(range_max_r));

  always_comb begin
    s_nxt = SHIFT_S_W'(62);
    for (int k = 30; k >= 0; k--) begin
      if ((sum_r >> (60 - 2 * k)) != '0) s_nxt = SHIFT_S_W'(2 * k);
    end
    n_nxt = SQRT_N_W'(sum_xy_r) << s_nxt;
  end

  // azimuth chain
  logic signed [CW-1:0]    az_x [0:CORDIC_STEPS];
  logic signed [CW-1:0]    az_y [0:CORDIC_STEPS];
  logic signed [ACC_W-1:0] az_a [0:CORDIC_STEPS];
  logic signed [CW-1:0]    ax_pre, ay_pre;
  logic signed [ACC_W-1:0] aa_pre;

  always_comb begin
    ax_pre = CW'(sb_r[ST_AZ0-1].x);
    ay_pre = CW'(sb_r[ST_AZ0-1].y);
    aa_pre = '0;
    if (sb_r[ST_AZ0-1].x < 0) begin
      aa_pre = sb_r[ST_AZ0-1].y[CB-1] ? -PI_Q24 : PI_Q24;
      ax_pre = -ax_pre;
      ay_pre = -ay_pre;
    end
  end

  // square root chain
  logic [SQRT_N_W-1:0]    sq_n    [0:SQRT_STEPS];
  logic [SQRT_REM_W-1:0]  sq_rem  [0:SQRT_STEPS];
  logic [SQRT_ROOT_W-1:0] sq_root [0:SQRT_STEPS];

  // elevation chain
  logic signed [CW-1:0]    el_x [0:CORDIC_STEPS];
  logic signed [CW-1:0]    el_y [0:CORDIC_STEPS];
  logic signed [ACC_W-1:0] el_a [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r    <= sb_r[1].x * sb_r[1].x;
      sqy_r    <= sb_r[1].y * sb_r[1].y;
      sqz_r    <= sb_r[1].z * sb_r[1].z;
      sum_xy_r <= sum_xy_nxt;
      sum_r    <= sum_nxt;
      az_x[0]  <= ax_pre <<< WORK_FRAC;
      az_y[0]  <= ay_pre <<< WORK_FRAC;
      az_a[0]  <= aa_pre;
      sq_n[0]    <= n_nxt;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      el_x[0] <= CW'({1'b0, sq_root[SQRT_STEPS]}) <<< WORK_FRAC;
      el_y[0] <= (CW'(sb_r[ST_EL0-1].z) <<< sb_r[ST_EL0-1].s[SHIFT_S_W-1:1]) <<< WORK_FRAC;
      el_a[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    pfc_cordic_cell #(.STEP(i), .CW(CW)) u_az (
      .clk(clk), .en(adv),
      .x_i(az_x[i]), .y_i(az_y[i]), .a_i(az_a[i]),
      .x_r(az_x[i+1]), .y_r(az_y[i+1]), .a_r(az_a[i+1])
    );
    pfc_cordic_cell #(.STEP(i), .CW(CW)) u_el (
      .clk(clk), .en(adv),
      .x_i(el_x[i]), .y_i(el_y[i]), .a_i(el_a[i]),
      .x_r(el_x[i+1]), .y_r(el_y[i+1]), .a_r(el_a[i+1])
    );
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    pfc_sqrt_cell #(.STEP(k)) u_sq (
      .clk(clk), .en(adv),
      .n_i(sq_n[k]), .rem_i(sq_rem[k]), .root_i(sq_root[k]),
      .n_r(sq_n[k+1]), .rem_r(sq_rem[k+1]), .root_r(sq_root[k+1])
    );
  end

  // window tests
  logic signed [BW-1:0] b_q [4];
  logic signed [BW-1:0] az_w, el_w;
  logic                 win_ok;

  always_comb begin
    for (int q = 0; q < 4; q++) begin
      b_q[q] = BW'($signed(fov_r[16*q +: 16])) <<< BSH;
    end
    az_w   = BW'(sb_r[ST_CMP-1].az);
    el_w   = BW'(el_a[CORDIC_STEPS]);
    win_ok = (az_w >= b_q[2]) && (az_w <= b_q[3]) &&
             (el_w >= b_q[0]) && (el_w <= b_q[1]);
  end

  // sideband line
  always_comb begin
    sb_nxt[1]   = '0;
    sb_nxt[1].v = in_ch.valid;
    sb_nxt[1].x = in_ch.sensor_x;
    sb_nxt[1].y = in_ch.sensor_y;
    sb_nxt[1].z = in_ch.sensor_z;
    for (int k = 2; k <= ST_LAST; k++) sb_nxt[k] = sb_r[k-1];
    sb_nxt[ST_AZ0].keep    = range_ok;
    sb_nxt[ST_AZ0].az_zero = (sb_r[ST_AZ0-1].x == 0) && (sb_r[ST_AZ0-1].y == 0);
    sb_nxt[ST_SQ0].s       = s_nxt;
    sb_nxt[ST_AZIN].az     = sb_r[ST_AZIN-1].az_zero ? '0 : az_a[CORDIC_STEPS];
    sb_nxt[ST_CMP].keep    = sb_r[ST_CMP-1].keep && win_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= ST_LAST; k++) sb_r[k].v <= 1'b0;
    end else if (adv) begin
      for (int k = 1; k <= ST_LAST; k++) sb_r[k] <= sb_nxt[k];
    end
  end

  // rotation products
  logic signed [PRD_W-1:0] prod_r [3][3];
  logic signed [CB-1:0]    pc [3];
  assign pc[0] = sb_r[ST_CMP].x;
  assign pc[1] = sb_r[ST_CMP].y;
  assign pc[2] = sb_r[ST_CMP].z;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[r][j] <= $signed(row_r[r][ENTRY_W*j +: ENTRY_W]) * pc[j];
        end
      end
    end
  end

  // round, translate, saturate
  localparam logic signed [PW-1:0] LO = -(PW'(1) <<< (CB - 1));
  localparam logic signed [PW-1:0] HI = (PW'(1) <<< (CB - 1)) - PW'(1);
  logic signed [PW-1:0] acc [3];
  logic signed [PW-1:0] wv  [3];
  logic signed [CB-1:0] sat [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = PW'(prod_r[r][0]) + PW'(prod_r[r][1]) + PW'(prod_r[r][2]);
      wv[r]  = ((acc[r] + PW'(8192)) >>> 14) +
               PW'($signed(shift_r[SHIFT_W*r +: SHIFT_W]));
      if (wv[r] < LO)      sat[r] = LO[CB-1:0];
      else if (wv[r] > HI) sat[r] = HI[CB-1:0];
      else                 sat[r] = wv[r][CB-1:0];
    end
  end

  logic signed [CB-1:0] wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sb_r[ST_LAST].v && sb_r[ST_LAST].keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= sat[0];
      wy_r <= sat[1];
      wz_r <= sat[2];
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.world_x = wx_r;
  assign out_ch.world_y = wy_r;
  assign out_ch.world_z = wz_r;

endmodule

[test/point_fov_crop_and_rigid_transform_top_tb.sv]
// Testbench for point_fov_crop_and_rigid_transform_top: drives sensor points
// and register writes, predicts world points and checks them in order.
// Depends on pfc_pkg, pfc_stream_if and the top level RTL.
`timescale 1ns / 1ps

module point_fov_crop_and_rigid_transform_top_tb import pfc_pkg::*; ();

  localparam int CB        = 24;
  localparam int AFB       = 12;
  localparam int HOLD_OFF  = 80;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } point_t;

  class fov_scoreboard;
    bit [47:0] range_lo, range_hi;
    bit [63:0] fov;
    bit [47:0] rows [3];
    bit [62:0] shift;
    point_t    world_q [$];
    int        errors;

    function new();
      range_lo = 48'd22500;
      range_hi = 48'd100000000;
      fov      = '0;
      rows[0]  = 48'd16384;
      rows[1]  = 48'd16384 << 16;
      rows[2]  = 48'd16384 << 32;
      shift    = '0;
      errors   = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [63:0] v);
      case (idx)
        REG_RANGE_MIN: range_lo = v[47:0];
        REG_RANGE_MAX: range_hi = v[47:0];
        REG_FOV:       fov      = v;
        REG_ROW_X:     rows[0]  = v[47:0];
        REG_ROW_Y:     rows[1]  = v[47:0];
        REG_ROW_Z:     rows[2]  = v[47:0];
        REG_SHIFT:     shift    = v[62:0];
        default: ;
      endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    // vectoring CORDIC, Q24 radians
    static function longint vector_angle(longint y, longint x);
      longint acc, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        acc = (y >= 0) ? 64'sd52707179 : -64'sd52707179;
        x = -x;
        y = -y;
      end
      x = x <<< WORK_FRAC;
      y = y <<< WORK_FRAC;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; acc += longint'(atan_q24(i));
        end else begin
          x -= dx; y += dy; acc -= longint'(atan_q24(i));
        end
      end
      return acc;
    endfunction

    function longint fov_bound(int slot);
      return longint'($signed(fov[16*slot +: 16])) <<< (WORK_FRAC - AFB);
    endfunction

    function void note_point(point_t pt);
      longint p [3];
      longint wv [3];
      longint unsigned sq_xy, sq, r;
      longint azim, elev, acc, v, lo, hi;
      int s;
      point_t w;
      p[0] = pt.x; p[1] = pt.y; p[2] = pt.z;
      sq_xy = p[0] * p[0] + p[1] * p[1];
      sq    = sq_xy + p[2] * p[2];
      if (sq <= range_lo || sq > range_hi) return;
      azim = vector_angle(p[1], p[0]);
      s = 0;
      while (s <= 60 && (sq >> (60 - s)) == 0) s += 2;
      r = int_sqrt(sq_xy << s);
      elev = vector_angle(p[2] <<< (s / 2), longint'(r));
      if (azim < fov_bound(2) || azim > fov_bound(3)) return;
      if (elev < fov_bound(0) || elev > fov_bound(1)) return;
      lo = -(64'sd1 <<< (CB - 1));
      hi = (64'sd1 <<< (CB - 1)) - 1;
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += longint'($signed(rows[k][16*j +: 16])) * p[j];
        v = ((acc + 8192) >>> 14) + longint'($signed(shift[21*k +: 21]));
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        wv[k] = v;
      end
      w.x = wv[0][CB-1:0]; w.y = wv[1][CB-1:0]; w.z = wv[2][CB-1:0];
      world_q = {world_q, w};
    endfunction

    function void check_result(point_t got);
      point_t want;
      if (world_q.size() == 0) begin
        $error("unexpected world point %0d %0d %0d", got.x, got.y, got.z);
        errors++;
        return;
      end
      want = world_q.pop_front();
      if (got.x !== want.x) begin
        $error("world_x expected %0d actual %0d", want.x, got.x); errors++;
      end
      if (got.y !== want.y) begin
        $error("world_y expected %0d actual %0d", want.y, got.y); errors++;
      end
      if (got.z !== want.z) begin
        $error("world_z expected %0d actual %0d", want.z, got.z); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pfc_in_if  #(.COORD_BITS(CB)) in_ch ();
  pfc_out_if #(.COORD_BITS(CB)) out_ch ();

  point_fov_crop_and_rigid_transform_top #(
    .COORD_BITS(CB), .ANGLE_FRAC_BITS(AFB)
  ) u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  fov_scoreboard sb = new();
  int  send_idle_pct;
  int  stall_pct;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.sensor_x = '0; in_ch.sensor_y = '0; in_ch.sensor_z = '0;
    out_ch.ready = 1'b0;
    send_idle_pct = 0; stall_pct = 0; quiet_cycles = 0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // sample both channels and count quiet cycles
  always @(posedge clk) begin
    point_t pt;
    logic   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        pt.x = in_ch.sensor_x; pt.y = in_ch.sensor_y; pt.z = in_ch.sensor_z;
        sb.note_point(pt);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        pt.x = out_ch.world_x; pt.y = out_ch.world_y; pt.z = out_ch.world_z;
        sb.check_result(pt);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_point(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                            logic signed [CB-1:0] z);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sensor_x <= x;
    in_ch.sensor_y <= y;
    in_ch.sensor_z <= z;
    // hold the beat until the edge that accepts it
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // lower valid, wait for the pipeline to empty
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.world_q.size() != 0) @(negedge clk);
    repeat (HOLD_OFF) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CB-1:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return CB'($urandom);
      1:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      2, 3:    return CB'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return CB'($signed($urandom_range(0, 40000)) - 20000);
    endcase
  endfunction

  function automatic logic [47:0] rand_row(int diag);
    logic [15:0] e [3];
    for (int j = 0; j < 3; j++) begin
      case ($urandom_range(0, 5))
        0:       e[j] = 16'($urandom);
        1:       e[j] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        default: e[j] = (j == diag) ? 16'd16384 - 16'($urandom_range(0, 2000))
                                    : 16'($signed($urandom_range(0, 8000)) - 4000);
      endcase
    end
    return {e[2], e[1], e[0]};
  endfunction

  task automatic open_window();
    write_reg(REG_RANGE_MIN, 64'd0);
    write_reg(REG_RANGE_MAX, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_FOV, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
  endtask

  task automatic random_points(int n, bit pause_midway);
    for (int i = 0; i < n; i++) begin
      if (pause_midway && i == n / 2) drain();
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // default registers: range boundaries and the zero-width window
    send_point(24'sd1000, 24'sd0, 24'sd0);
    send_point(24'sd0, 24'sd0, 24'sd0);
    send_point(24'sd150, 24'sd0, 24'sd0);
    send_point(24'sd151, 24'sd0, 24'sd0);
    send_point(24'sd10000, 24'sd0, 24'sd0);
    send_point(24'sd10001, 24'sd0, 24'sd0);
    send_point(-24'sd1000, 24'sd0, 24'sd0);
    send_point(-24'sd1000, -24'sd5, 24'sd0);
    send_point(24'sd0, 24'sd1000, 24'sd1000);
    drain();

    open_window();
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(24'sh800000, 24'sh800000, 24'sh800000);
    send_point(24'sh800000, 24'sd0, 24'sd0);
    send_point(24'sd0, 24'sd0, 24'sh7FFFFF);
    send_point(24'sd0, 24'sd0, -24'sd1);
    send_point(-24'sd3, -24'sd4, 24'sd12);
    send_point(-24'sd3, 24'sd4, -24'sd12);
    send_point(24'sd1, 24'sd0, 24'sd0);
    drain();
    // saturation at both ends
    write_reg(REG_ROW_X, {16'h7FFF, 16'h7FFF, 16'h7FFF});
    write_reg(REG_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_ROW_Z, {16'h8000, 16'h7FFF, 16'h0000});
    write_reg(REG_SHIFT, {21'h0FFFFF, 21'h100000, 21'h1FFFFF});
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(24'sh800000, 24'sh800000, 24'sh800000);
    send_point(24'sh7FFFFF, 24'sh800000, 24'sd5);
    drain();

    // no idling, identity rotation with a random shift
    write_reg(REG_ROW_X, 48'd16384);
    write_reg(REG_ROW_Y, 48'd16384 << 16);
    write_reg(REG_ROW_Z, 48'd16384 << 32);
    write_reg(REG_SHIFT, 64'($urandom) << 31 ^ 64'($urandom));
    random_points(200, 1'b1);

    // sender idle, random rotation, half-plane azimuth window
    send_idle_pct = 66;
    write_reg(REG_ROW_X, rand_row(0));
    write_reg(REG_ROW_Y, rand_row(1));
    write_reg(REG_ROW_Z, rand_row(2));
    write_reg(REG_FOV, {16'sd6434, -16'sd6434, 16'sd3000, -16'sd3000});
    random_points(180, 1'b0);

    // receiver stalls, moderate range gate
    send_idle_pct = 0;
    stall_pct = 66;
    write_reg(REG_RANGE_MIN, 64'd1000000);
    write_reg(REG_RANGE_MAX, 64'd4000000000000);
    write_reg(REG_FOV, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(REG_SHIFT, {21'($urandom), 21'($urandom), 21'($urandom)});
    random_points(180, 1'b0);

    // both sides idle, extreme rotation entries
    send_idle_pct = 32;
    stall_pct = 32;
    write_reg(REG_RANGE_MIN, 64'd0);
    write_reg(REG_RANGE_MAX, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_ROW_X, {16'h8000, 16'h7FFF, 16'h8000});
    write_reg(REG_ROW_Y, rand_row(1));
    write_reg(REG_ROW_Z, {16'h7FFF, 16'h8000, 16'h7FFF});
    random_points(180, 1'b0);

    // empty window, then random windows behind a closed and then an all-pass range gate
    write_reg(REG_FOV, {16'sd100, 16'sd200, 16'h7FFF, 16'h8000});
    random_points(30, 1'b0);
    send_idle_pct = 10;
    stall_pct = 10;
    write_reg(REG_FOV, {16'($urandom_range(0, 12000)), 16'(-$urandom_range(0, 12000)),
                        16'($urandom_range(0, 12000)), 16'(-$urandom_range(0, 12000))});
    write_reg(REG_RANGE_MIN, 64'hFFFF_FFFF_FFFF);
    random_points(20, 1'b0);
    write_reg(REG_RANGE_MIN, 64'd0);
    random_points(140, 1'b0);

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[point_fov_crop_and_rigid_transform_top.f]
rtl/core/pfc_pkg.sv
rtl/core/pfc_stream_if.sv
rtl/core/pfc_cordic_cell.sv
rtl/core/pfc_sqrt_cell.sv
rtl/core/point_fov_crop_and_rigid_transform_top.sv
test/point_fov_crop_and_rigid_transform_top_tb.sv
